// ----- hdl/scb_pkg.sv -----
`default_nettype none
package scb_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_BITS  = 16;
  localparam int FIX_W       = 32;
  localparam int FIELD_W     = 16;
  localparam int PIX_W       = 8;
  localparam int DIM_W       = 15;
  localparam int FETCH_W     = 16;
  localparam int NUM_W       = COORD_BITS + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
  localparam int CLIP_W      = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 1'd1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  localparam logic [DIM_W-1:0] DEST_WIDTH_RST  = 15'd320;
  localparam logic [DIM_W-1:0] DEST_HEIGHT_RST = 15'd200;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [FIX_W-1:0]             fix_t;

  typedef enum logic [1:0] {
    RK_ZERO,
    RK_DONE,
    RK_FIRST,
    RK_PIX
  } res_kind_e;

  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] dst_left;
    logic [FIELD_W-1:0] dst_top;
    logic [FIELD_W-1:0] dst_right;
    logic [FIELD_W-1:0] dst_bottom;
    logic [FIELD_W-1:0] src_left;
    logic [FIELD_W-1:0] src_top;
    logic [FIELD_W-1:0] src_right;
    logic [FIELD_W-1:0] src_bottom;
    logic               key_mode;
    logic [PIX_W-1:0]   pixel_in;
  } blit_in_t;

  typedef struct packed {
    logic      load_start;
    logic      div_start_u;
    logic      div_start_v;
    logic      store_u;
    logic      store_v;
    logic      mul_u;
    logic      mul_v;
    logic      fin;
    logic      pix_step;
    logic      res_load;
    res_kind_e res_kind;
  } cmd_t;

  typedef struct packed {
    logic early_empty;
    logic div_done;
    logic clip_empty;
    logic last_pix;
  } sts_t;

  typedef struct packed {
    logic                write_valid;
    logic [DIM_W-1:0]    write_x;
    logic [DIM_W-1:0]    write_y;
    logic [PIX_W-1:0]    write_pixel;
    logic                fetch_valid;
    logic [FETCH_W-1:0]  fetch_x;
    logic [FETCH_W-1:0]  fetch_y;
    logic                done_res;
  } res_t;

  // floor of a fixed-point value, low bits of the integer part
  function automatic logic [FETCH_W-1:0] fetch_of(input fix_t f);
    fetch_of = f[FRAC_BITS+FETCH_W-1:FRAC_BITS];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/scb_div.sv -----
`default_nettype none
module scb_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [scb_pkg::NUM_W-1:0]     num_i,
  input  wire logic [scb_pkg::COORD_BITS-1:0] den_i,
  input  wire logic                         neg_i,
  output      logic                         done_o,
  output      scb_pkg::fix_t                quot_o
);
  import scb_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [NUM_W-1:0]      acc_q, acc_d;
  logic [COORD_BITS:0]   rem_q, rem_d;
  logic [COORD_BITS-1:0] den_q, den_d;
  logic                  neg_q, neg_d;
  logic [COORD_BITS:0]   rem_sh;
  logic                  take;
  fix_t                  mag;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q[COORD_BITS-1:0], acc_q[NUM_W-1]};
  assign take   = (rem_sh >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(NUM_W);
      acc_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = neg_i;
    end else if (busy_q) begin
      rem_d = take ? (rem_sh - {1'b0, den_q}) : rem_sh;
      acc_d = {acc_q[NUM_W-2:0], take};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign mag    = FIX_W'(acc_q);
  assign quot_o = neg_q ? (fix_t'(0) - mag) : mag;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- hdl/scb_datapath.sv -----
`default_nettype none
module scb_datapath (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire scb_pkg::blit_in_t        in_i,
  input  wire logic [scb_pkg::DIM_W-1:0] dest_width_i,
  input  wire logic [scb_pkg::DIM_W-1:0] dest_height_i,
  input  wire scb_pkg::cmd_t            cmd_i,
  output      scb_pkg::sts_t            sts_o,
  output      scb_pkg::res_t            res_o
);
  import scb_pkg::*;

  coord_t in_x1, in_y1, in_x2, in_y2, in_s1, in_t1, in_s2, in_t2;
  logic signed [COORD_BITS:0] s1w, s2w, t1w, t2w;
  logic signed [COORD_BITS:0] du_in, dv_in;
  logic signed [FIX_W-1:0]    s1_ext, t1_ext;

  coord_t x1_q, y1_q, x2_q, y2_q;
  logic signed [COORD_BITS:0] du_q, dv_q;
  logic key_q;

  fix_t u_step_q, v_step_q, prod_q, u_row_start_q, u_now_q, v_now_q;
  coord_t col_first_q, col_end_q, row_end_q, col_now_q, row_now_q;

  // divider operands
  logic signed [COORD_BITS:0] diff, diff_abs;
  logic signed [COORD_BITS:0] x1w, x2w, y1w, y2w, len_x, len_y;
  logic [NUM_W-1:0]           div_num;
  logic [COORD_BITS-1:0]      div_den;
  logic                       div_start, div_done;
  fix_t                       div_quot;

  // clipping offset multiply
  logic signed [COORD_BITS:0] neg_x1, neg_y1;
  logic [COORD_BITS-1:0]      mul_a;
  fix_t                       mul_b;
  logic [FIX_W+COORD_BITS-1:0] prod_full;

  // clipping
  logic signed [CLIP_W-1:0] x2c_w, y2c_w, dw_w, dh_w;
  coord_t x1c, y1c, x2c, y2c;
  fix_t   v_first;

  // pixel walk
  coord_t col_next, row_next;
  logic   wrap, last, wr_en;
  fix_t   u_next, v_next;

  assign in_x1 = in_i.dst_left[COORD_BITS-1:0];
  assign in_y1 = in_i.dst_top[COORD_BITS-1:0];
  assign in_x2 = in_i.dst_right[COORD_BITS-1:0];
  assign in_y2 = in_i.dst_bottom[COORD_BITS-1:0];
  assign in_s1 = in_i.src_left[COORD_BITS-1:0];
  assign in_t1 = in_i.src_top[COORD_BITS-1:0];
  assign in_s2 = in_i.src_right[COORD_BITS-1:0];
  assign in_t2 = in_i.src_bottom[COORD_BITS-1:0];

  assign s1w    = (COORD_BITS+1)'(in_s1);
  assign s2w    = (COORD_BITS+1)'(in_s2);
  assign t1w    = (COORD_BITS+1)'(in_t1);
  assign t2w    = (COORD_BITS+1)'(in_t2);
  assign du_in  = s2w - s1w;
  assign dv_in  = t2w - t1w;
  assign s1_ext = FIX_W'(in_s1);
  assign t1_ext = FIX_W'(in_t1);

  assign sts_o.early_empty = (in_x2 <= in_x1) || (in_y2 <= in_y1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      x1_q  <= in_x1;
      y1_q  <= in_y1;
      x2_q  <= in_x2;
      y2_q  <= in_y2;
      du_q  <= du_in;
      dv_q  <= dv_in;
      key_q <= in_i.key_mode;
    end
  end

  // step = (delta << frac) / len, truncated toward zero
  assign x1w       = (COORD_BITS+1)'(x1_q);
  assign x2w       = (COORD_BITS+1)'(x2_q);
  assign y1w       = (COORD_BITS+1)'(y1_q);
  assign y2w       = (COORD_BITS+1)'(y2_q);
  assign len_x     = x2w - x1w;
  assign len_y     = y2w - y1w;
  assign diff      = cmd_i.div_start_v ? dv_q : du_q;
  assign diff_abs  = diff[COORD_BITS] ? -diff : diff;
  assign div_num   = {diff_abs[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign div_den   = cmd_i.div_start_v ? len_y[COORD_BITS-1:0] : len_x[COORD_BITS-1:0];
  assign div_start = cmd_i.div_start_u | cmd_i.div_start_v;

  scb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .neg_i   (diff[COORD_BITS]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign sts_o.div_done = div_done;

  // source advance for the part clipped off at the left or top
  assign neg_x1    = -x1w;
  assign neg_y1    = -y1w;
  assign mul_a     = cmd_i.mul_v ? ((y1_q < 0) ? neg_y1[COORD_BITS-1:0] : '0)
                                 : ((x1_q < 0) ? neg_x1[COORD_BITS-1:0] : '0);
  assign mul_b     = cmd_i.mul_v ? v_step_q : u_step_q;
  assign prod_full = {{FIX_W{1'b0}}, mul_a} * {{COORD_BITS{1'b0}}, mul_b};

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_u) u_step_q <= div_quot;
    if (cmd_i.store_v) v_step_q <= div_quot;
    if (cmd_i.mul_u || cmd_i.mul_v) prod_q <= prod_full[FIX_W-1:0];
  end

  // clip against the picture
  assign dw_w  = {{(CLIP_W-DIM_W){1'b0}}, dest_width_i};
  assign dh_w  = {{(CLIP_W-DIM_W){1'b0}}, dest_height_i};
  assign x2c_w = CLIP_W'(x2_q);
  assign y2c_w = CLIP_W'(y2_q);
  assign x1c   = (x1_q < 0) ? '0 : x1_q;
  assign y1c   = (y1_q < 0) ? '0 : y1_q;
  assign x2c   = (x2c_w > dw_w) ? dw_w[COORD_BITS-1:0] : x2_q;
  assign y2c   = (y2c_w > dh_w) ? dh_w[COORD_BITS-1:0] : y2_q;
  assign sts_o.clip_empty = (x2c <= x1c) || (y2c <= y1c);
  assign v_first = v_now_q + prod_q;

  // walk left to right, then top to bottom
  assign col_next = col_now_q + coord_t'(1);
  assign row_next = row_now_q + coord_t'(1);
  assign wrap     = (col_next >= col_end_q);
  assign last     = wrap && (row_next >= row_end_q);
  assign u_next   = wrap ? u_row_start_q : (u_now_q + u_step_q);
  assign v_next   = wrap ? (v_now_q + v_step_q) : v_now_q;
  assign wr_en    = !(key_q && (in_i.pixel_in == '0));
  assign sts_o.last_pix = last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      u_row_start_q <= fix_t'(s1_ext <<< FRAC_BITS);
      v_now_q       <= fix_t'(t1_ext <<< FRAC_BITS);
    end else if (cmd_i.mul_v) begin
      u_row_start_q <= u_row_start_q + prod_q;
    end else if (cmd_i.fin) begin
      v_now_q     <= v_first;
      u_now_q     <= u_row_start_q;
      col_first_q <= x1c;
      col_now_q   <= x1c;
      col_end_q   <= x2c;
      row_now_q   <= y1c;
      row_end_q   <= y2c;
    end else if (cmd_i.pix_step) begin
      col_now_q <= wrap ? col_first_q : col_next;
      row_now_q <= wrap ? row_next : row_now_q;
      u_now_q   <= u_next;
      v_now_q   <= v_next;
    end
  end

  always_comb begin
    res_o = '0;
    case (cmd_i.res_kind)
      RK_ZERO: res_o = '0;
      RK_DONE: res_o.done_res = 1'b1;
      RK_FIRST: begin
        res_o.fetch_valid = 1'b1;
        res_o.fetch_x     = fetch_of(u_row_start_q);
        res_o.fetch_y     = fetch_of(v_first);
      end
      RK_PIX: begin
        if (wr_en) begin
          res_o.write_valid = 1'b1;
          res_o.write_x     = DIM_W'(col_now_q);
          res_o.write_y     = DIM_W'(row_now_q);
          res_o.write_pixel = in_i.pixel_in;
        end
        if (last) begin
          res_o.done_res = 1'b1;
        end else begin
          res_o.fetch_valid = 1'b1;
          res_o.fetch_x     = fetch_of(u_next);
          res_o.fetch_y     = fetch_of(v_next);
        end
      end
      default: res_o = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/scb_ctrl.sv -----
`default_nettype none
module scb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_action_i,
  input  wire logic          out_free_i,
  input  wire scb_pkg::sts_t sts_i,
  output      logic          in_ready_o,
  output      scb_pkg::cmd_t cmd_o
);
  import scb_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV_U = 3'd1;
  localparam logic [2:0] ST_DIV_V = 3'd2;
  localparam logic [2:0] ST_MUL_U = 3'd3;
  localparam logic [2:0] ST_MUL_V = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_LOAD  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       busy_q, busy_d;

  always_comb begin
    state_d    = state_q;
    busy_d     = busy_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free_i;
        if (in_valid_i && out_free_i) begin
          if (in_action_i == ACT_START) begin
            // a new start drops any running blit
            cmd_o.load_start = 1'b1;
            busy_d           = 1'b0;
            if (sts_i.early_empty) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_kind = RK_DONE;
            end else begin
              // rectangle lands in the datapath registers first
              state_d = ST_LOAD;
            end
          end else begin
            cmd_o.res_load = 1'b1;
            if (busy_q) begin
              cmd_o.pix_step = 1'b1;
              cmd_o.res_kind = RK_PIX;
              if (sts_i.last_pix) busy_d = 1'b0;
            end else begin
              cmd_o.res_kind = RK_ZERO;
            end
          end
        end
      end
      ST_LOAD: begin
        cmd_o.div_start_u = 1'b1;
        state_d           = ST_DIV_U;
      end
      ST_DIV_U: begin
        if (sts_i.div_done) begin
          cmd_o.store_u     = 1'b1;
          cmd_o.div_start_v = 1'b1;
          state_d           = ST_DIV_V;
        end
      end
      ST_DIV_V: begin
        if (sts_i.div_done) begin
          cmd_o.store_v = 1'b1;
          state_d       = ST_MUL_U;
        end
      end
      ST_MUL_U: begin
        cmd_o.mul_u = 1'b1;
        state_d     = ST_MUL_V;
      end
      ST_MUL_V: begin
        cmd_o.mul_v = 1'b1;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        if (out_free_i) begin
          cmd_o.fin      = 1'b1;
          cmd_o.res_load = 1'b1;
          if (sts_i.clip_empty) begin
            cmd_o.res_kind = RK_DONE;
          end else begin
            cmd_o.res_kind = RK_FIRST;
            busy_d         = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/scaled_colorkey_blitter.sv -----
// pixel request: result registered, shown in the cycle after accept, one pixel per cycle while the output is free
// start request: the rectangle is loaded, then the bit-serial step divider is run twice,
//   then one shared 16x32 multiply per axis
// empty rectangle before clipping: result shown in the cycle after accept, next request at once
// reset: async active low, idles the controller, drops the running blit, empties the
//   output stage and sets the picture size to 320 x 200
`default_nettype none
module scaled_colorkey_blitter (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request stream
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // dst_left, dst_top, dst_right, dst_bottom, src_left, src_top, src_right,
  // src_bottom, key_mode, pixel_in, zero pad
  input  wire logic [scb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // action
  input  wire logic                              s_axis_tuser,
  // result stream
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // write_x, write_y, write_pixel, fetch_x, fetch_y, zero pad
  output      logic [scb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // write_valid, fetch_valid
  output      logic [scb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  // done_res
  output      logic                              m_axis_tlast,
  // register writes
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [scb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [scb_pkg::DIM_W-1:0]          cfg_data_i
);
  import scb_pkg::*;

  blit_in_t         in_fields;
  cmd_t             cmd;
  sts_t             sts;
  res_t             res_d, res_q;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic [DIM_W-1:0] dest_width_q, dest_height_q;

  // unpack request fields, lowest bits first
  assign in_fields.action     = s_axis_tuser;
  assign in_fields.dst_left   = s_axis_tdata[15:0];
  assign in_fields.dst_top    = s_axis_tdata[31:16];
  assign in_fields.dst_right  = s_axis_tdata[47:32];
  assign in_fields.dst_bottom = s_axis_tdata[63:48];
  assign in_fields.src_left   = s_axis_tdata[79:64];
  assign in_fields.src_top    = s_axis_tdata[95:80];
  assign in_fields.src_right  = s_axis_tdata[111:96];
  assign in_fields.src_bottom = s_axis_tdata[127:112];
  assign in_fields.key_mode   = s_axis_tdata[128];
  assign in_fields.pixel_in   = s_axis_tdata[136:129];

  // picture size registers, writable at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_width_q  <= DEST_WIDTH_RST;
      dest_height_q <= DEST_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DEST_WIDTH:  dest_width_q  <= cfg_data_i;
        REG_DEST_HEIGHT: dest_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output stage frees up in the same cycle its result is taken
  assign out_free = !out_valid_q || m_axis_tready;

  scb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .out_free_i  (out_free),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  scb_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_fields),
    .dest_width_i  (dest_width_q),
    .dest_height_i (dest_height_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .res_o         (res_d)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.res_load)       out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.res_load) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.fetch_y, res_q.fetch_x, res_q.write_pixel,
                          res_q.write_y, res_q.write_x};
  assign m_axis_tuser  = {res_q.fetch_valid, res_q.write_valid};
  assign m_axis_tlast  = res_q.done_res;

  // a result never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> out_free)
    else $error("result loaded over a pending result");

  // every accepted pixel request loads a result in the same cycle
  a_pixel_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_PIXEL)) |-> cmd.res_load)
    else $error("pixel request without result");

  // a finished blit asks for no further fetch
  a_done_no_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tlast && m_axis_tuser[1]))
    else $error("done together with fetch");

  // skipped writes carry zero coordinates and pixel
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      ((res_q.write_x == '0) && (res_q.write_y == '0) && (res_q.write_pixel == '0)))
    else $error("write fields set without write");

endmodule
`default_nettype wire
